@@ rtl/per_bin_reservoir_sampler_assert.svh @@
`ifndef PER_BIN_RESERVOIR_SAMPLER_ASSERT_SVH
`define PER_BIN_RESERVOIR_SAMPLER_ASSERT_SVH

// Both macros expect i_clk and i_rst_n in the module that uses them.

// The consequent must hold in the same cycle as the antecedent.
`define PBRS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PBRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/pbrs_pkg.sv @@
`timescale 1ns / 1ps

package pbrs_pkg;

    localparam int NUM_PHASES_DEF = 64;
    localparam int CAPACITY_DEF   = 256;

    localparam int PHASE_W    = 6;
    localparam int BOARD_W    = 64;
    localparam int BYTE_W     = 8;
    localparam int RAND_W     = 64;
    localparam int SLOT_W     = 8;
    localparam int STATUS_W   = 3;
    localparam int FILL_W     = 9;
    localparam int SEEN_W     = 48;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [SEEN_W-1:0] SEEN_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY   = 2'd2;

    localparam logic [PHASE_W-1:0] PHASE_LOW_RST  = 6'd0;
    localparam logic [PHASE_W-1:0] PHASE_HIGH_RST = 6'd63;
    localparam logic [FILL_W-1:0]  CAPACITY_RST   = 9'd256;

    typedef enum logic {
        OP_OFFER = 1'b0,
        OP_READ  = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_APPENDED   = 3'd0,
        ST_REPLACED   = 3'd1,
        ST_DISCARDED  = 3'd2,
        ST_OUTSIDE    = 3'd3,
        ST_READ_OK    = 3'd4,
        ST_READ_EMPTY = 3'd5
    } t_status;

    // Classified item as it travels from the front end to the back end.
    typedef struct packed {
        t_op                       op;
        logic [PHASE_W-1:0]        phase;
        logic                      bin_ok;
        logic                      in_win;
        logic [FILL_W-1:0]         cap;
        logic [BOARD_W-1:0]        own;
        logic [BOARD_W-1:0]        other;
        logic signed [BYTE_W-1:0]  side;
        logic signed [BYTE_W-1:0]  score;
        logic [RAND_W-1:0]         rnd;
        logic [SLOT_W-1:0]         read_slot;
    } t_cmd;

    typedef struct packed {
        logic [SEEN_W-1:0] seen;
        logic [FILL_W-1:0] fill;
    } t_bin_state;

    typedef struct packed {
        logic [BOARD_W-1:0]       own;
        logic [BOARD_W-1:0]       other;
        logic signed [BYTE_W-1:0] side;
        logic signed [BYTE_W-1:0] score;
    } t_entry;

    typedef struct packed {
        logic              start;
        logic [RAND_W-1:0] dividend;
        logic [SEEN_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [SEEN_W-1:0] rem;
    } t_div_rsp;

endpackage

@@ rtl/pbrs_in_if.sv @@
`timescale 1ns / 1ps

interface pbrs_in_if;
    import pbrs_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      op;
    logic [PHASE_W-1:0]        phase;
    logic [BOARD_W-1:0]        own_discs;
    logic [BOARD_W-1:0]        other_discs;
    logic signed [BYTE_W-1:0]  side;
    logic signed [BYTE_W-1:0]  score;
    logic [RAND_W-1:0]         random_word;
    logic [SLOT_W-1:0]         read_slot;

    modport source (
        output valid, op, phase, own_discs, other_discs, side, score, random_word,
               read_slot,
        input  ready
    );

    modport sink (
        input  valid, op, phase, own_discs, other_discs, side, score, random_word,
               read_slot,
        output ready
    );
endinterface

@@ rtl/pbrs_out_if.sv @@
`timescale 1ns / 1ps

interface pbrs_out_if;
    import pbrs_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic [SLOT_W-1:0]         slot;
    logic [BOARD_W-1:0]        entry_own;
    logic [BOARD_W-1:0]        entry_other;
    logic signed [BYTE_W-1:0]  entry_side;
    logic signed [BYTE_W-1:0]  entry_score;
    logic [FILL_W-1:0]         fill;
    logic [SEEN_W-1:0]         seen;

    modport source (
        output valid, status, slot, entry_own, entry_other, entry_side, entry_score,
               fill, seen,
        input  ready
    );

    modport sink (
        input  valid, status, slot, entry_own, entry_other, entry_side, entry_score,
               fill, seen,
        output ready
    );
endinterface

@@ rtl/pbrs_cfg_if.sv @@
`timescale 1ns / 1ps

interface pbrs_cfg_if;
    import pbrs_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/per_bin_reservoir_sampler.sv @@
// An input beat lands in a two-deep queue, which takes beats while the back end works. The
// back end pops an item in S_IDLE, looks up its bin in S_BIN, then reads the entry in S_ENT
// for a read that returns one or waits in S_DIV for a replace or discard, and hands the
// result to the output register in S_DONE; it works on one item at a time. S_DIV waits on
// the radix-4 remainder unit for random_word mod seen. Reset (synchronous, active low) clears
// control, the config registers and the per-bin counters at once; entry stores are not cleared.
`timescale 1ns / 1ps

module per_bin_reservoir_sampler #(
    parameter int NUM_PHASES = pbrs_pkg::NUM_PHASES_DEF,
    parameter int CAPACITY   = pbrs_pkg::CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pbrs_cfg_if.sink    i_cfg,
    pbrs_in_if.sink     i_in,
    pbrs_out_if.source  o_out
);
    import pbrs_pkg::*;

    t_cmd q_in;
    t_cmd q_out;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;

    pbrs_front #(
        .NUM_PHASES (NUM_PHASES),
        .CAPACITY   (CAPACITY)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (i_cfg),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_cmd    (q_in)
    );

    pbrs_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

    pbrs_back #(
        .NUM_PHASES (NUM_PHASES),
        .CAPACITY   (CAPACITY)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_cmd     (q_out),
        .o_pop     (q_pop),
        .o_out     (o_out)
    );
endmodule

@@ rtl/pbrs_ram.sv @@
`timescale 1ns / 1ps

module pbrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/pbrs_fifo.sv @@
`timescale 1ns / 1ps

module pbrs_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pbrs_pkg::t_cmd  i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output pbrs_pkg::t_cmd  o_data
);
    import pbrs_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end
endmodule

@@ rtl/pbrs_front.sv @@
`timescale 1ns / 1ps

module pbrs_front #(
    parameter int NUM_PHASES = pbrs_pkg::NUM_PHASES_DEF,
    parameter int CAPACITY   = pbrs_pkg::CAPACITY_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    pbrs_cfg_if.sink        i_cfg,
    pbrs_in_if.sink         i_in,
    input  logic            i_q_full,
    output logic            o_push,
    output pbrs_pkg::t_cmd  o_cmd
);
    import pbrs_pkg::*;

    logic [PHASE_W-1:0] r_phase_low;
    logic [PHASE_W-1:0] r_phase_high;
    logic [FILL_W-1:0]  r_capacity;
    logic [FILL_W-1:0]  cap;
    logic               bin_ok;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_low  <= PHASE_LOW_RST;
            r_phase_high <= PHASE_HIGH_RST;
            r_capacity   <= CAPACITY_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_PHASE_LOW:  r_phase_low  <= i_cfg.data[PHASE_W-1:0];
                CFG_PHASE_HIGH: r_phase_high <= i_cfg.data[PHASE_W-1:0];
                CFG_CAPACITY:   r_capacity   <= i_cfg.data[FILL_W-1:0];
                default: ;
            endcase
        end
    end

    // A capacity of zero keeps one entry; anything above the store depth is clipped.
    always_comb begin
        if (r_capacity == '0) begin
            cap = FILL_W'(1);
        end else if (int'(r_capacity) > CAPACITY) begin
            cap = FILL_W'(CAPACITY);
        end else begin
            cap = r_capacity;
        end
    end

    assign bin_ok = int'(i_in.phase) < NUM_PHASES;

    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;

    always_comb begin
        o_cmd.op        = t_op'(i_in.op);
        o_cmd.phase     = i_in.phase;
        o_cmd.bin_ok    = bin_ok;
        o_cmd.in_win    = bin_ok && (i_in.phase >= r_phase_low) &&
                          (i_in.phase <= r_phase_high);
        o_cmd.cap       = cap;
        o_cmd.own       = i_in.own_discs;
        o_cmd.other     = i_in.other_discs;
        o_cmd.side      = i_in.side;
        o_cmd.score     = i_in.score;
        o_cmd.rnd       = i_in.random_word;
        o_cmd.read_slot = i_in.read_slot;
    end
endmodule

@@ rtl/pbrs_div.sv @@
`timescale 1ns / 1ps

module pbrs_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pbrs_pkg::t_div_req i_req,
    output pbrs_pkg::t_div_rsp o_rsp
);
    import pbrs_pkg::*;

    // Radix-4 restoring remainder: two dividend bits per cycle.
    localparam int DIGITS = RAND_W / 2;
    localparam int CNT_W  = $clog2(DIGITS);
    localparam int T_W    = SEEN_W + 2;

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [RAND_W-1:0] r_x;
    logic [SEEN_W-1:0] r_d;
    logic [T_W-1:0]    r_d3;
    logic [SEEN_W-1:0] r_rem;
    logic [T_W-1:0]    trial;
    logic [T_W-1:0]    d1;
    logic [T_W-1:0]    d2;
    logic [SEEN_W-1:0] n_rem;

    assign trial = {r_rem, r_x[RAND_W-1 -: 2]};
    assign d1    = {2'b00, r_d};
    assign d2    = {1'b0, r_d, 1'b0};

    always_comb begin
        priority if (trial >= r_d3) begin
            n_rem = SEEN_W'(trial - r_d3);
        end else if (trial >= d2) begin
            n_rem = SEEN_W'(trial - d2);
        end else if (trial >= d1) begin
            n_rem = SEEN_W'(trial - d1);
        end else begin
            n_rem = SEEN_W'(trial);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(DIGITS - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x   <= i_req.dividend;
            r_d   <= i_req.divisor;
            r_d3  <= {2'b00, i_req.divisor} + {1'b0, i_req.divisor, 1'b0};
            r_rem <= '0;
        end else if (r_busy) begin
            r_x   <= {r_x[RAND_W-3:0], 2'b00};
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;
endmodule

@@ rtl/pbrs_back.sv @@
`timescale 1ns / 1ps
`include "per_bin_reservoir_sampler_assert.svh"

module pbrs_back #(
    parameter int NUM_PHASES = pbrs_pkg::NUM_PHASES_DEF,
    parameter int CAPACITY   = pbrs_pkg::CAPACITY_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_empty,
    input  pbrs_pkg::t_cmd  i_cmd,
    output logic            o_pop,
    pbrs_out_if.source      o_out
);
    import pbrs_pkg::*;

    localparam int BIN_W       = NUM_PHASES > 1 ? $clog2(NUM_PHASES) : 1;
    localparam int SLOT_AW     = CAPACITY > 1 ? $clog2(CAPACITY) : 1;
    localparam int ENT_DEPTH   = NUM_PHASES * CAPACITY;
    localparam int ENT_AW      = ENT_DEPTH > 1 ? $clog2(ENT_DEPTH) : 1;
    localparam int BIN_STATE_W = $bits(t_bin_state);
    localparam int ENTRY_W     = $bits(t_entry);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_BIN  = 5'b00010,
        S_DIV  = 5'b00100,
        S_ENT  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    typedef struct packed {
        t_status                  status;
        logic [SLOT_W-1:0]        slot;
        logic [BOARD_W-1:0]       own;
        logic [BOARD_W-1:0]       other;
        logic signed [BYTE_W-1:0] side;
        logic signed [BYTE_W-1:0] score;
        logic [FILL_W-1:0]        fill;
        logic [SEEN_W-1:0]        seen;
    } t_res;

    function automatic logic [ENT_AW-1:0] ent_addr(input logic [BIN_W-1:0]   bin_idx,
                                                   input logic [SLOT_AW-1:0] slot_idx);
        return ENT_AW'(bin_idx) * ENT_AW'(CAPACITY) + ENT_AW'(slot_idx);
    endfunction

    t_state                r_state, n_state;
    t_cmd                  r_cmd, n_cmd;
    t_res                  r_res, n_res;
    t_res                  r_out, n_out;
    logic                  r_out_vld, n_out_vld;
    logic [NUM_PHASES-1:0] r_bin_vld, n_bin_vld;

    logic [BIN_W-1:0]       bin;
    logic [BIN_STATE_W-1:0] bin_rdata;
    t_bin_state             cur;
    t_bin_state             bin_wdata;
    logic                   bin_we;
    logic [SEEN_W-1:0]      seen_inc;

    logic                   ent_we;
    logic [ENT_AW-1:0]      ent_waddr;
    logic [ENT_AW-1:0]      ent_raddr;
    t_entry                 ent_wdata;
    logic [ENTRY_W-1:0]     ent_rdata_raw;
    t_entry                 ent_rdata;

    t_div_req               div_req;
    t_div_rsp               div_rsp;

    assign bin = r_cmd.phase[BIN_W-1:0];

    // Bin counters: a bin that was never written since reset reads as empty.
    assign cur      = (r_cmd.bin_ok && r_bin_vld[bin]) ? t_bin_state'(bin_rdata) : '0;
    assign seen_inc = (cur.seen == SEEN_MAX) ? cur.seen : cur.seen + 1'b1;

    assign ent_wdata = '{own: r_cmd.own, other: r_cmd.other,
                         side: r_cmd.side, score: r_cmd.score};
    assign ent_raddr = ent_addr(bin, SLOT_AW'(r_cmd.read_slot));
    assign ent_rdata = t_entry'(ent_rdata_raw);

    pbrs_ram #(
        .WIDTH (BIN_STATE_W),
        .DEPTH (NUM_PHASES)
    ) u_bin_ram (
        .i_clk   (i_clk),
        .i_we    (bin_we),
        .i_waddr (bin),
        .i_wdata (bin_wdata),
        .i_raddr (i_cmd.phase[BIN_W-1:0]),
        .o_rdata (bin_rdata)
    );

    pbrs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENT_DEPTH)
    ) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rdata_raw)
    );

    pbrs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_res     = r_res;
        n_out     = r_out;
        n_out_vld = r_out_vld;
        n_bin_vld = r_bin_vld;
        o_pop     = 1'b0;
        bin_we    = 1'b0;
        bin_wdata = '{seen: seen_inc, fill: cur.fill};
        ent_we    = 1'b0;
        ent_waddr = ent_addr(bin, SLOT_AW'(cur.fill));
        div_req   = '0;

        if (r_out_vld && o_out.ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_cmd;
                    n_state = S_BIN;
                end
            end
            S_BIN: begin
                n_res      = '0;
                n_res.fill = cur.fill;
                n_res.seen = cur.seen;
                n_state    = S_DONE;
                if (r_cmd.op == OP_READ) begin
                    if (r_cmd.bin_ok && ({1'b0, r_cmd.read_slot} < cur.fill)) begin
                        n_res.status = ST_READ_OK;
                        n_res.slot   = r_cmd.read_slot;
                        n_state      = S_ENT;
                    end else begin
                        n_res.status = ST_READ_EMPTY;
                    end
                end else if (!r_cmd.in_win) begin
                    n_res.status = ST_OUTSIDE;
                end else begin
                    bin_we         = 1'b1;
                    n_bin_vld[bin] = 1'b1;
                    n_res.seen     = seen_inc;
                    if (cur.fill < r_cmd.cap) begin
                        ent_we         = 1'b1;
                        bin_wdata.fill = cur.fill + 1'b1;
                        n_res.status   = ST_APPENDED;
                        n_res.slot     = SLOT_W'(cur.fill);
                        n_res.fill     = cur.fill + 1'b1;
                    end else begin
                        div_req.start    = 1'b1;
                        div_req.dividend = r_cmd.rnd;
                        div_req.divisor  = seen_inc;
                        n_state          = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_state = S_DONE;
                    if (div_rsp.rem < SEEN_W'(r_cmd.cap)) begin
                        ent_we       = 1'b1;
                        ent_waddr    = ent_addr(bin, SLOT_AW'(div_rsp.rem));
                        n_res.status = ST_REPLACED;
                        n_res.slot   = SLOT_W'(div_rsp.rem);
                    end else begin
                        n_res.status = ST_DISCARDED;
                    end
                end
            end
            S_ENT: begin
                n_res.own   = ent_rdata.own;
                n_res.other = ent_rdata.other;
                n_res.side  = ent_rdata.side;
                n_res.score = ent_rdata.score;
                n_state     = S_DONE;
            end
            S_DONE: begin
                // Hand over once the output register is free or drains this beat.
                if (!r_out_vld || o_out.ready) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_bin_vld <= '0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            r_bin_vld <= n_bin_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_res <= n_res;
        r_out <= n_out;
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.status      = r_out.status;
    assign o_out.slot        = r_out.slot;
    assign o_out.entry_own   = r_out.own;
    assign o_out.entry_other = r_out.other;
    assign o_out.entry_side  = r_out.side;
    assign o_out.entry_score = r_out.score;
    assign o_out.fill        = r_out.fill;
    assign o_out.seen        = r_out.seen;

    `PBRS_ASSERT_SAME(a_div_only_when_full, div_req.start, r_cmd.op == OP_OFFER && r_cmd.in_win && cur.fill >= r_cmd.cap, "division started for a bin that still has room")
    `PBRS_ASSERT_SAME(a_no_write_during_div, r_state == S_DIV && !div_rsp.done, !ent_we, "entry written before the slot is known")
    `PBRS_ASSERT_NEXT(a_div_closes_item, r_state == S_DIV && div_rsp.done, r_state == S_DONE, "replacement decision did not finish the item")
    `PBRS_ASSERT_SAME(a_seen_grows, bin_we, bin_wdata.seen >= cur.seen && bin_wdata.seen != '0, "seen count went backward or stayed zero")
endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import pbrs_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int BIN_SLOTS   = NUM_PHASES_DEF * CAPACITY_DEF;

    typedef struct packed {
        t_op                       op;
        logic [PHASE_W-1:0]        phase;
        logic [BOARD_W-1:0]        own;
        logic [BOARD_W-1:0]        other;
        logic signed [BYTE_W-1:0]  side;
        logic signed [BYTE_W-1:0]  score;
        logic [RAND_W-1:0]         rnd;
        logic [SLOT_W-1:0]         read_slot;
    } t_beat;

    typedef struct packed {
        t_status                   status;
        logic [SLOT_W-1:0]         slot;
        logic [BOARD_W-1:0]        own;
        logic [BOARD_W-1:0]        other;
        logic signed [BYTE_W-1:0]  side;
        logic signed [BYTE_W-1:0]  score;
        logic [FILL_W-1:0]         fill;
        logic [SEEN_W-1:0]         seen;
    } t_result;

    typedef enum logic {
        ROW_CFG  = 1'b0,
        ROW_BEAT = 1'b1
    } t_row_kind;

    typedef struct {
        t_row_kind           kind;
        logic [PHASE_W-1:0]  lo;
        logic [PHASE_W-1:0]  hi;
        logic [FILL_W-1:0]   cap;
        t_beat               beat;
        bit                  typed;
        t_result             want;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    pbrs_cfg_if cfg_bus ();
    pbrs_in_if  in_bus ();
    pbrs_out_if out_bus ();

    per_bin_reservoir_sampler DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // Shadow of the sampler: window, capacity and per-bin reservoirs.
    logic [PHASE_W-1:0] win_lo;
    logic [PHASE_W-1:0] win_hi;
    int unsigned        cap_eff;
    bit [SEEN_W-1:0]    bin_seen [NUM_PHASES_DEF];
    int unsigned        bin_fill [NUM_PHASES_DEF];
    bit [BOARD_W-1:0]   own_mem [BIN_SLOTS];
    bit [BOARD_W-1:0]   other_mem [BIN_SLOTS];
    bit [BYTE_W-1:0]    side_mem [BIN_SLOTS];
    bit [BYTE_W-1:0]    score_mem [BIN_SLOTS];

    t_result  pending_results [$];
    t_dir_row dir_rows [$];

    int mismatches;
    int beats_sent;
    int results_checked;
    int status_tally [8];
    int burst_left;
    int stall_cycles;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_PHASE_LOW: begin
                win_lo = val[PHASE_W-1:0];
            end
            CFG_PHASE_HIGH: begin
                win_hi = val[PHASE_W-1:0];
            end
            CFG_CAPACITY: begin
                // Zero behaves as one, anything past the store depth as the full depth.
                if (val == 0) cap_eff = 1;
                else if (val > CAPACITY_DEF) cap_eff = CAPACITY_DEF;
                else cap_eff = 32'(val);
            end
            default: begin
            end
        endcase
    endfunction

    function automatic t_result reservoir_update(t_beat b);
        t_result     r;
        int unsigned idx;
        logic [RAND_W-1:0] pick;
        r = '0;
        r.status = ST_READ_EMPTY;
        if (b.op == OP_OFFER) begin
            if (b.phase < win_lo || b.phase > win_hi) begin
                r.status = ST_OUTSIDE;
            end else begin
                if (bin_seen[b.phase] != SEEN_MAX) bin_seen[b.phase]++;
                if (bin_fill[b.phase] < cap_eff) begin
                    r.status = ST_APPENDED;
                    r.slot = SLOT_W'(bin_fill[b.phase]);
                    bin_fill[b.phase]++;
                end else begin
                    pick = b.rnd % {{(RAND_W-SEEN_W){1'b0}}, bin_seen[b.phase]};
                    if (pick < cap_eff) begin
                        r.status = ST_REPLACED;
                        r.slot = pick[SLOT_W-1:0];
                    end else begin
                        r.status = ST_DISCARDED;
                    end
                end
                if (r.status != ST_DISCARDED) begin
                    idx = b.phase * CAPACITY_DEF + r.slot;
                    own_mem[idx] = b.own;
                    other_mem[idx] = b.other;
                    side_mem[idx] = b.side;
                    score_mem[idx] = b.score;
                end
            end
        end else if (b.read_slot < bin_fill[b.phase]) begin
            // Reads ignore the window; only the fill count of the bin matters.
            idx = b.phase * CAPACITY_DEF + b.read_slot;
            r.status = ST_READ_OK;
            r.slot = b.read_slot;
            r.own = own_mem[idx];
            r.other = other_mem[idx];
            r.side = side_mem[idx];
            r.score = score_mem[idx];
        end
        r.fill = FILL_W'(bin_fill[b.phase]);
        r.seen = bin_seen[b.phase];
        return r;
    endfunction

    function automatic t_beat mk_beat(t_op op, logic [PHASE_W-1:0] ph, logic [BOARD_W-1:0] own,
                                      logic [BOARD_W-1:0] other, logic [BYTE_W-1:0] side,
                                      logic [BYTE_W-1:0] score, logic [RAND_W-1:0] rnd,
                                      logic [SLOT_W-1:0] rslot);
        t_beat b;
        b.op = op;
        b.phase = ph;
        b.own = own;
        b.other = other;
        b.side = side;
        b.score = score;
        b.rnd = rnd;
        b.read_slot = rslot;
        return b;
    endfunction

    function automatic t_result mk_result(t_status st, logic [SLOT_W-1:0] slot,
                                          logic [BOARD_W-1:0] own, logic [BOARD_W-1:0] other,
                                          logic [BYTE_W-1:0] side, logic [BYTE_W-1:0] score,
                                          logic [FILL_W-1:0] fill, logic [SEEN_W-1:0] seen);
        t_result r;
        r.status = st;
        r.slot = slot;
        r.own = own;
        r.other = other;
        r.side = side;
        r.score = score;
        r.fill = fill;
        r.seen = seen;
        return r;
    endfunction

    function automatic t_dir_row cfg_row(logic [PHASE_W-1:0] lo, logic [PHASE_W-1:0] hi,
                                         logic [FILL_W-1:0] cap);
        t_dir_row row;
        row.kind = ROW_CFG;
        row.lo = lo;
        row.hi = hi;
        row.cap = cap;
        row.beat = '0;
        row.typed = 1'b0;
        row.want = '0;
        return row;
    endfunction

    function automatic t_dir_row beat_row(t_beat b, bit typed, t_result want);
        t_dir_row row;
        row.kind = ROW_BEAT;
        row.lo = '0;
        row.hi = '0;
        row.cap = '0;
        row.beat = b;
        row.typed = typed;
        row.want = want;
        return row;
    endfunction

    function automatic t_beat random_beat(int unsigned flo, int unsigned fhi);
        t_beat b;
        b.phase = ($urandom_range(0, 9) == 0) ? PHASE_W'($urandom_range(0, 63))
                                               : PHASE_W'($urandom_range(flo, fhi));
        b.op = ($urandom_range(0, 99) < 18) ? OP_READ : OP_OFFER;
        if (bin_fill[b.phase] > 0 && $urandom_range(0, 3) != 0)
            b.read_slot = SLOT_W'($urandom_range(0, bin_fill[b.phase] - 1));
        else
            b.read_slot = SLOT_W'($urandom_range(0, 255));
        case ($urandom_range(0, 7))
            0: b.own = '0;
            1: b.own = '1;
            default: b.own = {$urandom, $urandom};
        endcase
        case ($urandom_range(0, 7))
            0: b.other = '0;
            1: b.other = '1;
            default: b.other = {$urandom, $urandom};
        endcase
        b.side = BYTE_W'($urandom);
        b.score = BYTE_W'($urandom);
        // Small random words land below the capacity far more often than full ones.
        case ($urandom_range(0, 5))
            0: b.rnd = '1;
            1, 2: b.rnd = RAND_W'($urandom_range(0, 511));
            default: b.rnd = {$urandom, $urandom};
        endcase
        return b;
    endfunction

    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 20);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_bus.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    task automatic drive_beat(input t_beat b, input bit typed, input t_result want,
                              output t_status st);
        t_result r;
        in_bus.valid <= 1'b1;
        in_bus.op <= b.op;
        in_bus.phase <= b.phase;
        in_bus.own_discs <= b.own;
        in_bus.other_discs <= b.other;
        in_bus.side <= b.side;
        in_bus.score <= b.score;
        in_bus.random_word <= b.rnd;
        in_bus.read_slot <= b.read_slot;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
        r = reservoir_update(b);
        pending_results.push_back(typed ? want : r);
        beats_sent++;
        st = r.status;
    endtask

    task automatic cfg_beat(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data <= val;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        apply_reg(idx, val);
    endtask

    // Registers only change once the block has handed back every result.
    task automatic write_regs(logic [PHASE_W-1:0] lo, logic [PHASE_W-1:0] hi,
                              logic [FILL_W-1:0] cap);
        in_bus.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        cfg_beat(CFG_PHASE_LOW, CFG_DATA_W'(lo));
        cfg_beat(CFG_PHASE_HIGH, CFG_DATA_W'(hi));
        cfg_beat(CFG_CAPACITY, cap);
        cfg_bus.valid <= 1'b0;
        burst_left = 0;
    endtask

    task automatic random_phase(logic [PHASE_W-1:0] lo, logic [PHASE_W-1:0] hi,
                                logic [FILL_W-1:0] cap, int unsigned flo, int unsigned fhi,
                                int count);
        int      counted;
        t_status st;
        write_regs(lo, hi, cap);
        counted = 0;
        while (counted < count) begin
            pace_sender();
            drive_beat(random_beat(flo, fhi), 1'b0, '0, st);
            counted++;
        end
    endtask

    initial begin : stimulus
        t_status     st;
        int unsigned lo;
        int unsigned hi;
        i_rst_n <= 1'b0;
        cfg_bus.valid <= 1'b0;
        cfg_bus.index <= '0;
        cfg_bus.data <= '0;
        in_bus.valid <= 1'b0;
        in_bus.op <= OP_OFFER;
        in_bus.phase <= '0;
        in_bus.own_discs <= '0;
        in_bus.other_discs <= '0;
        in_bus.side <= '0;
        in_bus.score <= '0;
        in_bus.random_word <= '0;
        in_bus.read_slot <= '0;
        win_lo = PHASE_LOW_RST;
        win_hi = PHASE_HIGH_RST;
        cap_eff = CAPACITY_RST;
        mismatches = 0;
        beats_sent = 0;
        results_checked = 0;
        burst_left = 0;

        // Extremes after reset, then each capacity and window corner.
        dir_rows.push_back(beat_row(mk_beat(OP_READ, 6'd5, '0, '0, '0, '0, '0, 8'd0), 1'b1,
                                    mk_result(ST_READ_EMPTY, '0, '0, '0, '0, '0, '0, '0)));
        dir_rows.push_back(beat_row(mk_beat(OP_OFFER, 6'd0, '1, '0, 8'h80, 8'h7f, '0, 8'd0),
                                    1'b1,
                                    mk_result(ST_APPENDED, '0, '0, '0, '0, '0, 9'd1, 48'd1)));
        dir_rows.push_back(beat_row(mk_beat(OP_OFFER, 6'd63, '0, '1, 8'h7f, 8'h80, '1, 8'hff),
                                    1'b1,
                                    mk_result(ST_APPENDED, '0, '0, '0, '0, '0, 9'd1, 48'd1)));
        dir_rows.push_back(beat_row(mk_beat(OP_READ, 6'd0, '0, '0, '0, '0, '0, 8'd0), 1'b1,
                                    mk_result(ST_READ_OK, '0, '1, '0, 8'h80, 8'h7f, 9'd1,
                                              48'd1)));
        dir_rows.push_back(beat_row(mk_beat(OP_READ, 6'd63, '1, '1, '1, '1, '1, 8'd0), 1'b1,
                                    mk_result(ST_READ_OK, '0, '0, '1, 8'h7f, 8'h80, 9'd1,
                                              48'd1)));
        dir_rows.push_back(beat_row(mk_beat(OP_READ, 6'd0, '0, '0, '0, '0, '0, 8'hff), 1'b1,
                                    mk_result(ST_READ_EMPTY, '0, '0, '0, '0, '0, 9'd1, 48'd1)));
        dir_rows.push_back(cfg_row(6'd0, 6'd63, 9'd0));
        dir_rows.push_back(beat_row(mk_beat(OP_OFFER, 6'd0, 64'h1234, 64'h5678, 8'h01,
                                            8'hfe, 64'd0, 8'd0),
                                    1'b1,
                                    mk_result(ST_REPLACED, '0, '0, '0, '0, '0, 9'd1, 48'd2)));
        dir_rows.push_back(beat_row(mk_beat(OP_OFFER, 6'd0, '1, '1, '1, '1, 64'd1, 8'd0),
                                    1'b1,
                                    mk_result(ST_DISCARDED, '0, '0, '0, '0, '0, 9'd1, 48'd3)));
        dir_rows.push_back(cfg_row(6'd0, 6'd63, 9'd511));
        dir_rows.push_back(beat_row(mk_beat(OP_OFFER, 6'd0, 64'haaaa_5555_aaaa_5555,
                                            64'h5555_aaaa_5555_aaaa, 8'h7f, 8'h80, '1, 8'd0),
                                    1'b0, '0));
        dir_rows.push_back(beat_row(mk_beat(OP_OFFER, 6'd0, 64'hdead_beef, 64'hcafe, 8'hff,
                                            8'h00, 64'd5, 8'd0), 1'b0, '0));
        dir_rows.push_back(beat_row(mk_beat(OP_READ, 6'd0, '0, '0, '0, '0, '0, 8'd2), 1'b0, '0));
        // Capacity lowered below what bin 0 already holds.
        dir_rows.push_back(cfg_row(6'd0, 6'd63, 9'd1));
        dir_rows.push_back(beat_row(mk_beat(OP_OFFER, 6'd0, 64'h77, 64'h88, 8'h10, 8'h20,
                                            64'd0, 8'd0), 1'b0, '0));
        dir_rows.push_back(beat_row(mk_beat(OP_OFFER, 6'd0, 64'h99, 64'haa, 8'h30, 8'h40,
                                            64'd2, 8'd0), 1'b0, '0));
        dir_rows.push_back(beat_row(mk_beat(OP_READ, 6'd0, '0, '0, '0, '0, '0, 8'd0), 1'b0, '0));
        // Empty window: low above high.
        dir_rows.push_back(cfg_row(6'd10, 6'd5, 9'd256));
        dir_rows.push_back(beat_row(mk_beat(OP_OFFER, 6'd7, '1, '1, '1, '1, '1, 8'd0), 1'b1,
                                    mk_result(ST_OUTSIDE, '0, '0, '0, '0, '0, '0, '0)));
        dir_rows.push_back(beat_row(mk_beat(OP_OFFER, 6'd0, '1, '1, '1, '1, '1, 8'd0), 1'b0, '0));
        dir_rows.push_back(cfg_row(6'd20, 6'd40, 9'd1));
        dir_rows.push_back(beat_row(mk_beat(OP_OFFER, 6'd19, '1, '0, '0, '0, '0, 8'd0), 1'b0, '0));
        dir_rows.push_back(beat_row(mk_beat(OP_OFFER, 6'd41, '0, '1, '0, '0, '0, 8'd0), 1'b0, '0));
        dir_rows.push_back(beat_row(mk_beat(OP_OFFER, 6'd20, 64'h1, 64'h2, 8'h03, 8'h04,
                                            64'd0, 8'd0), 1'b0, '0));
        dir_rows.push_back(beat_row(mk_beat(OP_OFFER, 6'd40, 64'h5, 64'h6, 8'h07, 8'h08,
                                            64'd0, 8'd0), 1'b0, '0));
        dir_rows.push_back(beat_row(mk_beat(OP_OFFER, 6'd40, 64'h9, 64'ha, 8'h0b, 8'h0c,
                                            '1, 8'd0), 1'b0, '0));
        dir_rows.push_back(beat_row(mk_beat(OP_OFFER, 6'd40, 64'hd, 64'he, 8'h0f, 8'h10,
                                            64'd6, 8'd0), 1'b0, '0));
        dir_rows.push_back(beat_row(mk_beat(OP_READ, 6'd40, '0, '0, '0, '0, '0, 8'd0), 1'b0, '0));
        dir_rows.push_back(beat_row(mk_beat(OP_READ, 6'd0, '0, '0, '0, '0, '0, 8'd2), 1'b0, '0));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                write_regs(dir_rows[i].lo, dir_rows[i].hi, dir_rows[i].cap);
            end else begin
                pace_sender();
                drive_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want, st);
            end
        end

        random_phase(6'd0, 6'd63, 9'd3, 0, 7, 100);
        random_phase(6'd8, 6'd15, 9'd1, 6, 17, 100);
        // One bin at full capacity, long enough to run well past 256 offers.
        random_phase(6'd50, 6'd50, 9'd256, 50, 50, 420);
        random_phase(6'd0, 6'd63, 9'd2, 48, 52, 120);
        random_phase(6'd63, 6'd0, 9'h1ff, 0, 63, 30);
        repeat (2) begin
            lo = $urandom_range(0, 63);
            hi = $urandom_range(0, 63);
            random_phase(PHASE_W'(lo), PHASE_W'(hi), FILL_W'($urandom_range(1, 16)),
                         (lo <= hi) ? lo : 0, (lo <= hi) ? hi : 63, 60);
        end

        in_bus.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("Run covered %0d input beats and %0d results.", beats_sent, results_checked);
        $display("Offers: %0d appends, %0d replaces, %0d discards, %0d out of window.",
                 status_tally[ST_APPENDED], status_tally[ST_REPLACED],
                 status_tally[ST_DISCARDED], status_tally[ST_OUTSIDE]);
        $display("Reads returned %0d entries and %0d empty slots; %0d mismatches.",
                 status_tally[ST_READ_OK], status_tally[ST_READ_EMPTY], mismatches);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // The receiver runs random stall modes and, every few hundred results, a long hold-off.
    initial begin : receiver
        int mode;
        int mode_left;
        int hold_left;
        int taken;
        int next_hold;
        out_bus.ready <= 1'b0;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        taken = 0;
        next_hold = 150;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_bus.valid && out_bus.ready) taken++;
            if (hold_left == 0 && taken >= next_hold) begin
                hold_left = 400;
                next_hold += 450;
            end
            if (mode_left == 0) begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(8, 64);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                out_bus.ready <= 1'b0;
            end else begin
                case (mode)
                    0: out_bus.ready <= 1'b1;
                    1: out_bus.ready <= ($urandom_range(0, 1) == 0);
                    2: out_bus.ready <= ($urandom_range(0, 3) == 0);
                    default: out_bus.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            got.status = t_status'(out_bus.status);
            got.slot = out_bus.slot;
            got.own = out_bus.entry_own;
            got.other = out_bus.entry_other;
            got.side = out_bus.entry_side;
            got.score = out_bus.entry_score;
            got.fill = out_bus.fill;
            got.seen = out_bus.seen;
            results_checked++;
            status_tally[got.status]++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result beat with nothing expected: status %0d slot %0d",
                             $realtime, got.status, got.slot);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.slot !== want.slot ||
                    got.own !== want.own || got.other !== want.other ||
                    got.side !== want.side || got.score !== want.score ||
                    got.fill !== want.fill || got.seen !== want.seen) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: expected status %0d slot %0d own %h other %h",
                                 $realtime, want.status, want.slot, want.own, want.other);
                        $display("%0t:          side %0d score %0d fill %0d seen %0d",
                                 $realtime, want.side, want.score, want.fill, want.seen);
                        $display("%0t:   actual status %0d slot %0d own %h other %h",
                                 $realtime, got.status, got.slot, got.own, got.other);
                        $display("%0t:          side %0d score %0d fill %0d seen %0d",
                                 $realtime, got.side, got.score, got.fill, got.seen);
                    end
                end
            end
        end
    end

    // Ends the run if no beat moves on any channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
            (cfg_bus.valid && cfg_bus.ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no beat accepted for %0d cycles.", STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

endmodule
